@@ rtl/b64sc_pkg.sv @@
`default_nettype none
package b64sc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [1:0] REG_DIRECTION = 2'd0;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [CNT_W-1:0]            count;
    logic                        last;
    logic                        err;
  } burst_t;

  function automatic logic [7:0] char_of(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end
    return t[5:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/b64sc_if.sv @@
`default_nettype none
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       error;

  modport source (output valid, output out_byte, output out_last, output error, input ready);
  modport sink (input valid, input out_byte, input out_last, input error, output ready);
endinterface
`default_nettype wire

@@ rtl/b64sc_burst.sv @@
`default_nettype none
module b64sc_burst
  import b64sc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire burst_t       res,
  output logic              free,
  b64sc_out_if.source       out_ch
);

  logic [MAX_RESULTS-1:0][7:0] data;
  logic [CNT_W-1:0]            rem;
  logic                        last;
  logic                        err;
  logic                        fire;

  assign fire = out_ch.valid && out_ch.ready;
  assign free = (rem == '0) || ((rem == CNT_W'(1)) && out_ch.ready);

  assign out_ch.valid    = (rem != '0);
  assign out_ch.out_byte = data[0];
  assign out_ch.out_last = last && (rem == CNT_W'(1));
  assign out_ch.error    = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= res.count;
    end else if (fire) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res.data;
      last <= res.last;
      err  <= res.err;
    end else if (fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        data[i] <= data[i+1];
      end
      data[MAX_RESULTS-1] <= 8'd0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (rem == '0) || ((rem == CNT_W'(1)) && fire))
    else $error("burst overwritten");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.error) |-> (out_ch.out_last && (out_ch.out_byte == 8'd0)))
    else $error("error item malformed");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |-> ((res.count != '0) && (res.count <= CNT_W'(MAX_RESULTS))))
    else $error("bad burst count");

endmodule
`default_nettype wire

@@ rtl/base64_stream_codec_unit.sv @@
// Data path: an accepted item is held in the input register, processed combinationally
// from there, and loaded into the burst register, from which its results are offered.
// Throughput: one item per cycle into the input register while the burst register is
// free or the item produces no result; results leave the burst register at one per
// cycle when out_ch is ready and set the encode rate; decode sustains one char per cycle.
// Reset (rst, synchronous): direction encode, group state cleared, no items held.
`default_nettype none
module base64_stream_codec_unit
  import b64sc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  b64sc_in_if.sink         in_ch,
  b64sc_out_if.source      out_ch
);

  logic        direction;
  logic [1:0]  pos;
  logic [23:0] held;
  logic        pad_mark;

  logic [1:0]  pos_next;
  logic [23:0] held_next;
  logic        pad_mark_next;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  logic        cfg_wr;
  logic        produces;
  logic        burst_free;
  logic        s1_adv;
  burst_t      res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_DIRECTION);
  assign prdata = (paddr == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  assign s1_adv      = s1_valid && (!produces || burst_free);
  assign in_ch.ready = !s1_valid || s1_adv;

  always_comb begin
    logic [23:0] h;
    logic [23:0] hn;
    logic [5:0]  s;
    logic [1:0]  n;
    logic        is_pad;
    h             = 24'd0;
    s             = sextet_of(s1_byte);
    is_pad        = (s1_byte == PAD_CHAR);
    n             = pos + 2'd1;
    pos_next      = n;
    held_next     = held;
    pad_mark_next = pad_mark;
    produces      = 1'b0;
    res           = '0;
    if (direction == DIR_ENCODE) begin
      hn        = {held[15:0], s1_byte};
      held_next = hn;
      if ((n == 2'd3) || s1_last) begin
        produces = 1'b1;
        case (n)
          2'd1:    h = {s1_byte, 16'd0};
          2'd2:    h = {held[7:0], s1_byte, 8'd0};
          default: h = hn;
        endcase
        res.data[0] = char_of(h[23:18]);
        res.data[1] = char_of(h[17:12]);
        res.data[2] = (n == 2'd1) ? PAD_CHAR : char_of(h[11:6]);
        res.data[3] = (n != 2'd3) ? PAD_CHAR : char_of(h[5:0]);
        res.count   = CNT_W'(4);
        res.last    = s1_last;
        pos_next      = 2'd0;
        held_next     = 24'd0;
        pad_mark_next = 1'b0;
      end
    end else begin
      hn        = {held[17:0], s};
      held_next = hn;
      if (pos == 2'd2) begin
        pad_mark_next = is_pad;
      end
      if (n != 2'd0) begin
        if (s1_last) begin
          produces      = 1'b1;
          res.count     = CNT_W'(1);
          res.last      = 1'b1;
          res.err       = 1'b1;
          pos_next      = 2'd0;
          held_next     = 24'd0;
          pad_mark_next = 1'b0;
        end
      end else begin
        produces    = 1'b1;
        res.data[0] = hn[23:16];
        res.data[1] = hn[15:8];
        res.data[2] = hn[7:0];
        if (is_pad) begin
          res.count = pad_mark ? CNT_W'(1) : CNT_W'(2);
        end else begin
          res.count = CNT_W'(3);
        end
        res.last      = s1_last;
        pos_next      = 2'd0;
        held_next     = 24'd0;
        pad_mark_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.in_byte;
      s1_last <= in_ch.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      pos       <= 2'd0;
      held      <= 24'd0;
      pad_mark  <= 1'b0;
    end else if (cfg_wr) begin
      direction <= pwdata[0];
      pos       <= 2'd0;
      held      <= 24'd0;
      pad_mark  <= 1'b0;
    end else if (s1_adv) begin
      pos      <= pos_next;
      held     <= held_next;
      pad_mark <= pad_mark_next;
    end
  end

  b64sc_burst u_burst (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_adv && produces),
    .res    (res),
    .free   (burst_free),
    .out_ch (out_ch)
  );

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (pos == 2'd0) && (held == 24'd0) && !pad_mark)
    else $error("group state not cleared by config write");

  a_encode_shape: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && produces && (direction == DIR_ENCODE)) |-> (!res.err && (res.count == CNT_W'(4))))
    else $error("encode burst malformed");

  a_encode_pos: assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_ENCODE) |-> (pos != 2'd3))
    else $error("encode group overrun");

endmodule
`default_nettype wire

@@ tb/base64_stream_codec_unit_checker.sv @@
`timescale 1ns / 1ps
module base64_stream_codec_unit_checker
  import b64sc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  b64sc_in_if              in_mon,
  b64sc_out_if             out_mon,
  output int               errors,
  output int               outstanding
);

  localparam logic [1:0] DIR_ADDR = 2'(4 * REG_DIRECTION);
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } coded_t;

  coded_t      coded_q[$];
  coded_t      head;
  int          fails;
  logic        dir;
  logic [1:0]  grp_pos;
  logic [23:0] grp_bits;
  logic        third_pad;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return B64_ALPHABET[s];
  endfunction

  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= "A" && c <= "Z") begin
      t = c - 8'h41;
    end else if (c >= "a" && c <= "z") begin
      t = c - 8'h61 + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      t = c - 8'h30 + 8'd52;
    end else if (c == "+") begin
      t = 8'd62;
    end else if (c == "/") begin
      t = 8'd63;
    end
    return t[5:0];
  endfunction

  task automatic clear_group();
    grp_pos   = 2'd0;
    grp_bits  = 24'd0;
    third_pad = 1'b0;
  endtask

  task automatic expect_out(input logic [7:0] d, input logic l, input logic e);
    coded_t r;
    r.data = d;
    r.last = l;
    r.err  = e;
    coded_q.insert(coded_q.size(), r);
  endtask

  task automatic code_item(input logic [7:0] b, input logic l);
    logic [23:0] h;
    int          cnt;
    if (dir == DIR_ENCODE) begin
      grp_bits = {grp_bits[15:0], b};
      grp_pos  = grp_pos + 2'd1;
      if (grp_pos == 2'd3 || l) begin
        case (grp_pos)
          2'd1:    h = {grp_bits[7:0], 16'h0000};
          2'd2:    h = {grp_bits[15:0], 8'h00};
          default: h = grp_bits;
        endcase
        expect_out(sextet_char(h[23:18]), 1'b0, 1'b0);
        expect_out(sextet_char(h[17:12]), 1'b0, 1'b0);
        expect_out((grp_pos == 2'd1) ? PAD_CHAR : sextet_char(h[11:6]), 1'b0, 1'b0);
        expect_out((grp_pos != 2'd3) ? PAD_CHAR : sextet_char(h[5:0]), l, 1'b0);
        clear_group();
      end
    end else begin
      grp_bits = {grp_bits[17:0], char_value(b)};
      if (grp_pos == 2'd2) begin
        third_pad = (b == PAD_CHAR);
      end
      grp_pos = grp_pos + 2'd1;
      if (grp_pos != 2'd0) begin
        if (l) begin
          expect_out(8'h00, 1'b1, 1'b1);
          clear_group();
        end
      end else begin
        cnt = (b == PAD_CHAR) ? (third_pad ? 1 : 2) : 3;
        for (int k = 0; k < cnt; k++) begin
          expect_out(8'(grp_bits >> (16 - 8 * k)), l && (k == cnt - 1), 1'b0);
        end
        clear_group();
      end
    end
  endtask

  initial begin
    fails = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      dir = DIR_ENCODE;
      clear_group();
      coded_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == DIR_ADDR) begin
        dir = pwdata[0];
        clear_group();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (coded_q.size() == 0) begin
          $error("unexpected item: out_byte %02h out_last %0b error %0b",
                 out_mon.out_byte, out_mon.out_last, out_mon.error);
          fails++;
        end else begin
          head = coded_q.pop_front();
          if (out_mon.out_byte !== head.data) begin
            $error("out_byte: expected %02h, got %02h", head.data, out_mon.out_byte);
            fails++;
          end
          if (out_mon.out_last !== head.last) begin
            $error("out_last: expected %0b, got %0b", head.last, out_mon.out_last);
            fails++;
          end
          if (out_mon.error !== head.err) begin
            $error("error: expected %0b, got %0b", head.err, out_mon.error);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        code_item(in_mon.in_byte, in_mon.in_last);
      end
    end
    errors      <= fails;
    outstanding <= coded_q.size();
  end

endmodule

@@ tb/base64_stream_codec_unit_tb.sv @@
`timescale 1ns / 1ps
module base64_stream_codec_unit_tb;
  import b64sc_pkg::*;

  localparam logic [1:0] DIR_ADDR = 2'(4 * REG_DIRECTION);
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          send_calm;
  logic [7:0]  stream_q[$];

  b64sc_in_if  in_ch();
  b64sc_out_if out_ch();

  base64_stream_codec_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  base64_stream_codec_unit_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_stream(input bit end_it);
    foreach (stream_q[i]) begin
      send_item(stream_q[i], end_it && (i == stream_q.size() - 1));
    end
    stream_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      stream_q.insert(stream_q.size(), s[i]);
    end
  endtask

  task automatic load_direction(input logic d);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIR_ADDR;
    pwdata  <= {31'd0, d};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_quads(input int quads, input int pads);
    for (int i = 0; i < 4 * quads; i++) begin
      if (i >= 4 * quads - pads) begin
        stream_q.insert(stream_q.size(), PAD_CHAR);
      end else begin
        stream_q.insert(stream_q.size(), B64_ALPHABET[$urandom_range(0, 63)]);
      end
    end
  endtask

  initial begin
    int kind;
    int count;
    int cut;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= 2'd0;
    pwdata        <= 32'd0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    send_calm     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_direction(DIR_ENCODE);
    stream_q = '{8'h00, 8'hFF, 8'h80, 8'hFF};
    send_stream(1'b1);
    stream_q = '{8'h00, 8'h7F};
    send_stream(1'b1);

    load_direction(DIR_DECODE);
    push_text("AB=CTWE=");
    send_stream(1'b1);
    push_text("TQ==");
    send_stream(1'b1);
    stream_q = '{8'h00, PAD_CHAR, 8'hFF, "z"};
    send_stream(1'b1);
    push_text("9");
    send_stream(1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      load_direction((phase % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
      count = 0;
      while (count < 20) begin
        kind = $urandom_range(0, 9);
        if (phase % 2 == 0) begin
          repeat ($urandom_range(1, 9)) begin
            stream_q.insert(stream_q.size(), 8'($urandom_range(0, 255)));
          end
        end else begin
          push_quads($urandom_range(1, 3), $urandom_range(0, 2));
          if (kind == 7) begin
            repeat ($urandom_range(1, 2)) begin
              stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
          end else if (kind == 8) begin
            cut = $urandom_range(1, 3);
            repeat (cut) void'(stream_q.pop_back());
          end
        end
        count += stream_q.size();
        send_stream(kind != 9);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("base64_stream_codec_unit_tb: done, clean");
    end else begin
      $display("base64_stream_codec_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    int calm;
    int taken;
    bit held_once;
    out_ch.ready <= 1'b0;
    calm      = 0;
    taken     = 0;
    held_once = 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_wait(calm);
      if (!held_once && taken >= 40) begin
        held_once = 1'b1;
        stall     = 80;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    #200000;
    $display("base64_stream_codec_unit_tb: done, errors");
    $finish;
  end

endmodule
